// ===== hdl/mmwg_pkg.sv =====
// ----------------------------------------------------------------------------
// mmwg_pkg
// Shared types and constants of the multi-mode waveform generator.
// ----------------------------------------------------------------------------
package mmwg_pkg;

    localparam int MODE_W       = 2;
    localparam int CYCLE_LEN_W  = 13;
    localparam int PEAK_W       = 11;
    localparam int HALF_W       = 9;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int SAMPLE_W     = 12;
    localparam int SINE_W       = 12;
    localparam int PHASE_FRAC_W = 16;
    localparam int TRI_QUO_W    = 13;
    localparam int STEP_W       = 5;
    localparam int MAG_W        = 13;
    localparam int SUM_W        = 15;

    localparam logic [SAMPLE_W-1:0]    FULL_SCALE     = 12'd4095;
    localparam logic signed [SUM_W-1:0] MID_SCALE     = 15'sd2047;
    localparam logic [MAG_W-1:0]       SINE_PEAK      = 13'd2048;
    localparam logic [HALF_W-1:0]      PULSE_MAX_HALF = 9'd256;

    localparam logic [MODE_W-1:0]      RST_WAVE_MODE  = 2'd0;
    localparam logic [CYCLE_LEN_W-1:0] RST_CYCLE_LEN  = 13'd64;
    localparam logic [PEAK_W-1:0]      RST_PEAK       = 11'd2047;
    localparam logic [HALF_W-1:0]      RST_HALF       = 9'd32;

    localparam logic [STEP_W-1:0]      DIV_STEPS_SINE = 5'd16;
    localparam logic [STEP_W-1:0]      DIV_STEPS_TRI  = 5'd13;

    typedef enum logic [MODE_W-1:0] {
        MODE_SINE     = 2'd0,
        MODE_PULSE    = 2'd1,
        MODE_TRIANGLE = 2'd2,
        MODE_CONST    = 2'd3
    } wave_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_MODE   = 2'd0,
        REG_CYCLE_LEN   = 2'd1,
        REG_PEAK        = 2'd2,
        REG_HALF_PERIOD = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_ADDR,
        ST_READ,
        ST_FINISH
    } gen_state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/mmwg_serial_div.sv =====
// ----------------------------------------------------------------------------
// mmwg_serial_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend bits
// shifted in MSB first behind a preloaded partial remainder.
// ----------------------------------------------------------------------------
module mmwg_serial_div #(
    parameter int DIV_W = 13
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mmwg_pkg::div_cmd_t                 cmd,
    input  logic [DIV_W-1:0]                   rem_init,
    input  logic [mmwg_pkg::PHASE_FRAC_W-1:0]  low_bits,
    input  logic [DIV_W-1:0]                   divisor,
    output mmwg_pkg::div_stat_t                stat,
    output logic [mmwg_pkg::PHASE_FRAC_W-1:0]  quotient
);
    import mmwg_pkg::*;

    logic                    busy_reg;
    logic [STEP_W-1:0]       cnt_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [PHASE_FRAC_W-1:0] dvd_reg;
    logic [PHASE_FRAC_W-1:0] quo_reg;

    logic [DIV_W:0]          shifted;
    logic                    fits;
    logic [DIV_W-1:0]        rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[PHASE_FRAC_W-1]};
        fits     = (shifted >= {1'b0, div_reg});
        rem_next = fits ? DIV_W'(shifted - {1'b0, div_reg}) : DIV_W'(shifted);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= rem_init;
            div_reg <= divisor;
            dvd_reg <= low_bits;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[PHASE_FRAC_W-2:0], 1'b0};
            quo_reg <= {quo_reg[PHASE_FRAC_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == STEP_W'(1));
    assign quotient  = quo_reg;

endmodule

// ===== hdl/mmwg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// mmwg_sine_rom
// Quarter-wave sine table, round(2048*sin), with registered read data.
// ----------------------------------------------------------------------------
module mmwg_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                         clk,
    input  logic [$clog2(DEPTH)-1:0]     addr,
    output logic [mmwg_pkg::SINE_W-1:0]  data
);
    import mmwg_pkg::*;

    localparam real HALF_PI    = 1.57079632679489661923;
    localparam real ANGLE_STEP = HALF_PI / DEPTH;

    typedef logic [SINE_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_table();
        rom_t tbl;
        real  val;
        for (int j = 0; j < DEPTH; j++)
        begin
            val = 2048.0 * $sin(ANGLE_STEP * j);
            if (val > 2048.0)
                val = 2048.0;
            if (val < 0.0)
                val = 0.0;
            tbl[j] = SINE_W'($rtoi(val + 0.5));
        end
        return tbl;
    endfunction

    localparam rom_t SINE_ROM = build_table();

    logic [SINE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

// ===== hdl/multi_mode_waveform_generator_top.sv =====
// ----------------------------------------------------------------------------
// multi_mode_waveform_generator_top
// One 12-bit DAC sample per request: sine, pulse, triangle or full scale.
// Usage: a request on in_valid/in_ready carries restart; restart clears the
// sample index before that sample. Each request yields one sample on
// out_valid/out_ready. Registers are written on cfg_write (cfg_index,
// cfg_data); the user must write them only while no request is in flight.
// The block does not enforce this. Sine passes ST_PREP, ST_MUL, ST_DIV,
// ST_SCALE, ST_ADDR, ST_READ (table lookup) and ST_FINISH; triangle passes
// ST_PREP, ST_MUL, ST_DIV and ST_FINISH; pulse and constant go straight to
// ST_FINISH. Bit-serial divider: 16 quotient bits for sine, 13 for triangle.
// in_ready is high only while no request is in progress. A finished sample
// waits in the output register; if the receiver stalls, the next request is
// still accepted and computed, then held until the output register frees.
// Reset: both sample indices clear, registers take mode sine, cycle 64,
// peak 2047, half period 32; no output is pending.
// ----------------------------------------------------------------------------
module multi_mode_waveform_generator_top #(
    parameter int MAX_CYCLE        = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mmwg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mmwg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mmwg_pkg::SAMPLE_W-1:0]    sample
);
    import mmwg_pkg::*;

    localparam int CW     = $clog2(MAX_CYCLE + 1);
    localparam int PW     = $clog2(MAX_CYCLE);
    localparam int CMPW   = (CW > CYCLE_LEN_W) ? CW : CYCLE_LEN_W;
    localparam int MW     = PEAK_W + 2 + CW;
    localparam int TW     = CW + 2;
    localparam int KSCALE = 4 * SINE_TABLE_DEPTH;
    localparam int KW     = $clog2(KSCALE);
    localparam int KPW    = PHASE_FRAC_W + $clog2(KSCALE + 1);
    localparam int AW     = $clog2(SINE_TABLE_DEPTH);

    // configuration registers
    wave_mode_t             wave_mode_reg;
    logic [CYCLE_LEN_W-1:0] cycle_length_reg;
    logic [PEAK_W-1:0]      peak_value_reg;
    logic [HALF_W-1:0]      pulse_half_period_reg;

    // control state
    gen_state_t             state_reg;
    gen_state_t             state_next;
    logic [PW-1:0]          phase_position_reg;
    logic [PW-1:0]          phase_position_next;
    logic [HALF_W-1:0]      pulse_position_reg;
    logic [HALF_W-1:0]      pulse_position_next;
    logic                   out_valid_reg;

    // datapath
    logic [PW-1:0]          p_reg;
    logic [CW-1:0]          c_reg;
    logic                   pulse_hi_reg;
    logic [CW-1:0]          d_reg;
    logic                   neg_reg;
    logic [KW-1:0]          k_reg;
    logic [AW-1:0]          addr_reg;
    logic                   special_reg;
    logic [SAMPLE_W-1:0]    sample_reg;

    logic                   in_accept;
    logic                   out_load;
    logic                   wave_active;
    div_cmd_t               div_cmd;
    div_stat_t              div_stat;
    logic [PHASE_FRAC_W-1:0] div_quo;
    logic [CW-1:0]          div_rem_init;
    logic [PHASE_FRAC_W-1:0] div_low;
    logic [SINE_W-1:0]      rom_data;

    // request-time position handling
    logic [CMPW-1:0]        cyc_ext;
    logic [CW-1:0]          cyc_eff;
    logic [CW-1:0]          pos_sel;
    logic [CW-1:0]          pos_use;
    logic [CW-1:0]          pos_inc;
    logic [HALF_W-1:0]      half_eff;
    logic [HALF_W:0]        two_half;
    logic [HALF_W-1:0]      pp_sel;
    logic [HALF_W-1:0]      pp_use;
    logic [HALF_W:0]        pp_inc;

    // triangle segment / multiply / sine scale and address
    logic [TW-1:0]          t_p;
    logic [TW-1:0]          t_c;
    logic [TW-1:0]          t_q1;
    logic [TW-1:0]          t_q3;
    logic [TW-1:0]          t_hc;
    logic [CW-1:0]          d_next;
    logic                   neg_next;
    logic [MW-1:0]          tri_m;
    logic [KPW-1:0]         k_prod;
    logic [1:0]             quad;
    logic [KW-1:0]          j_full;
    logic [AW-1:0]          addr_next;

    // result
    logic [MAG_W-1:0]       mag;
    logic signed [SUM_W-1:0] wide;
    logic [SAMPLE_W-1:0]    clamped;
    logic [SAMPLE_W-1:0]    fin_sample;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign wave_active = (wave_mode_reg == MODE_SINE) || (wave_mode_reg == MODE_TRIANGLE);

    // sample index handling at request time
    always_comb
    begin
        cyc_ext = CMPW'(cycle_length_reg);
        if (cyc_ext == '0)
            cyc_eff = CW'(1);
        else if (cyc_ext > CMPW'(MAX_CYCLE))
            cyc_eff = CW'(MAX_CYCLE);
        else
            cyc_eff = CW'(cyc_ext);

        pos_sel = restart ? '0 : CW'(phase_position_reg);
        pos_use = (pos_sel >= cyc_eff) ? '0 : pos_sel;
        pos_inc = pos_use + 1'b1;
        phase_position_next = (pos_inc >= cyc_eff) ? '0 : PW'(pos_inc);

        if (pulse_half_period_reg == '0)
            half_eff = HALF_W'(1);
        else if (pulse_half_period_reg > PULSE_MAX_HALF)
            half_eff = PULSE_MAX_HALF;
        else
            half_eff = pulse_half_period_reg;
        two_half = {half_eff, 1'b0};

        pp_sel = restart ? '0 : pulse_position_reg;
        pp_use = ({1'b0, pp_sel} >= two_half) ? '0 : pp_sel;
        pp_inc = {1'b0, pp_use} + 1'b1;
        pulse_position_next = (pp_inc >= two_half) ? '0 : pp_inc[HALF_W-1:0];
    end

    // triangle segment select
    always_comb
    begin
        t_p  = TW'(p_reg);
        t_c  = TW'(c_reg);
        t_q1 = t_c >> 2;
        t_q3 = (t_c + (t_c << 1)) >> 2;
        t_hc = t_c >> 1;
        if (t_p <= t_q1)
        begin
            d_next   = CW'(t_p);
            neg_next = 1'b0;
        end
        else if (t_p <= t_q3)
        begin
            if (t_p <= t_hc)
            begin
                d_next   = CW'(t_hc - t_p);
                neg_next = 1'b0;
            end
            else
            begin
                d_next   = CW'(t_p - t_hc);
                neg_next = 1'b1;
            end
        end
        else
        begin
            d_next   = CW'(t_c - t_p);
            neg_next = 1'b1;
        end
    end

    // divider operands: triangle 4*peak*d / c, sine pos*65536 / c
    always_comb
    begin
        tri_m = (MW'(peak_value_reg) * MW'(d_reg)) << 2;
        if (wave_mode_reg == MODE_TRIANGLE)
        begin
            div_rem_init = tri_m[MW-1:TRI_QUO_W];
            div_low      = {tri_m[TRI_QUO_W-1:0], {(PHASE_FRAC_W - TRI_QUO_W){1'b0}}};
        end
        else
        begin
            div_rem_init = CW'(p_reg);
            div_low      = '0;
        end
    end

    // sine quadrant and table address
    always_comb
    begin
        k_prod = KPW'(div_quo) * KPW'(KSCALE);
        if (k_reg >= KW'(3 * SINE_TABLE_DEPTH))
        begin
            quad   = 2'd3;
            j_full = k_reg - KW'(3 * SINE_TABLE_DEPTH);
        end
        else if (k_reg >= KW'(2 * SINE_TABLE_DEPTH))
        begin
            quad   = 2'd2;
            j_full = k_reg - KW'(2 * SINE_TABLE_DEPTH);
        end
        else if (k_reg >= KW'(SINE_TABLE_DEPTH))
        begin
            quad   = 2'd1;
            j_full = k_reg - KW'(SINE_TABLE_DEPTH);
        end
        else
        begin
            quad   = 2'd0;
            j_full = k_reg;
        end
        if (quad[0] && (j_full != '0))
            addr_next = AW'(KW'(SINE_TABLE_DEPTH) - j_full);
        else if (quad[0])
            addr_next = '0;
        else
            addr_next = AW'(j_full);
    end

    // final sample
    always_comb
    begin
        if (wave_mode_reg == MODE_TRIANGLE)
            mag = div_quo[TRI_QUO_W-1:0];
        else if (special_reg)
            mag = SINE_PEAK;
        else
            mag = MAG_W'(rom_data);
        if (neg_reg)
            wide = MID_SCALE - signed'(SUM_W'(mag));
        else
            wide = MID_SCALE + signed'(SUM_W'(mag));
        if (wide < 0)
            clamped = '0;
        else if (wide > signed'(SUM_W'(FULL_SCALE)))
            clamped = FULL_SCALE;
        else
            clamped = wide[SAMPLE_W-1:0];
        case (wave_mode_reg)
            MODE_SINE:     fin_sample = clamped;
            MODE_TRIANGLE: fin_sample = clamped;
            MODE_PULSE:    fin_sample = pulse_hi_reg ? FULL_SCALE : '0;
            default:       fin_sample = FULL_SCALE;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        div_cmd.start = 1'b0;
        div_cmd.steps = DIV_STEPS_SINE;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = wave_active ? ST_PREP : ST_FINISH;
            end
            ST_PREP:
                state_next = ST_MUL;
            ST_MUL:
            begin
                div_cmd.start = 1'b1;
                div_cmd.steps = (wave_mode_reg == MODE_TRIANGLE) ? DIV_STEPS_TRI
                                                                 : DIV_STEPS_SINE;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = (wave_mode_reg == MODE_SINE) ? ST_SCALE : ST_FINISH;
            end
            ST_SCALE:
                state_next = ST_ADDR;
            ST_ADDR:
                state_next = ST_READ;
            ST_READ:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            out_valid_reg         <= 1'b0;
            phase_position_reg    <= '0;
            pulse_position_reg    <= '0;
            wave_mode_reg         <= wave_mode_t'(RST_WAVE_MODE);
            cycle_length_reg      <= RST_CYCLE_LEN;
            peak_value_reg        <= RST_PEAK;
            pulse_half_period_reg <= RST_HALF;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (in_accept)
            begin
                phase_position_reg <= phase_position_next;
                pulse_position_reg <= pulse_position_next;
            end
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_WAVE_MODE:   wave_mode_reg <= wave_mode_t'(cfg_data[MODE_W-1:0]);
                    REG_CYCLE_LEN:   cycle_length_reg <= cfg_data[CYCLE_LEN_W-1:0];
                    REG_PEAK:        peak_value_reg <= cfg_data[PEAK_W-1:0];
                    REG_HALF_PERIOD: pulse_half_period_reg <= cfg_data[HALF_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_reg        <= PW'(pos_use);
            c_reg        <= cyc_eff;
            pulse_hi_reg <= (pp_use < half_eff);
        end
        if (state_reg == ST_PREP)
        begin
            d_reg   <= d_next;
            neg_reg <= neg_next;
        end
        if (state_reg == ST_SCALE)
            k_reg <= k_prod[PHASE_FRAC_W +: KW];
        if (state_reg == ST_ADDR)
        begin
            addr_reg    <= addr_next;
            special_reg <= quad[0] && (j_full == '0);
            neg_reg     <= quad[1];
        end
        if (out_load)
            sample_reg <= fin_sample;
    end

    mmwg_serial_div #(
        .DIV_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .low_bits (div_low),
        .divisor  (c_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    mmwg_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (addr_reg),
        .data (rom_data)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after a request");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside divide state");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && !out_ready |=> (state_reg == ST_FINISH))
        else $error("result dropped while output stalled");
`endif

endmodule
